[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked by clk_i, off while rst_ni is low.
`ifndef NO_ASSERTIONS
`define ERS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ERS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ERS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ERS_ASSERT(lbl, prop)
`define ERS_ASSERT_IMP(lbl, ante, cons)
`define ERS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/ers_pkg.sv]
package ers_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 12;
  localparam int QUEUE_DEPTH    = 2;

  localparam int CFG_W       = 12;
  localparam int UPC_W       = 8;
  localparam int DIST_W      = 16;
  localparam int RES_FIXED_W = 50;

  localparam logic [UPC_W-1:0]  US_PER_CM_RST    = 8'd58;
  localparam logic [CFG_W-1:0]  SAMPLE_COUNT_RST = 12'd1000;
  localparam logic [DIST_W-1:0] DIST_MAX         = 16'hFFFF;

  localparam logic REG_US_PER_CM    = 1'b0;
  localparam logic REG_SAMPLE_COUNT = 1'b1;

  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic KIND_DIST = 1'b0;
  localparam logic KIND_STAT = 1'b1;

  typedef enum logic {
    CMD_RANGE,
    CMD_SAMPLE
  } cmd_e;

  typedef enum logic [1:0] {
    DIV_RANGE,
    DIV_MEAN,
    DIV_SSN,
    DIV_VAR
  } div_tag_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_EMIT_D,
    ST_DIV,
    ST_SQRT,
    ST_EMIT_S
  } state_e;

endpackage

[design/ers_fifo.sv]
module ers_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wptr_q] <= data_i;
    end
  end
endmodule

[design/ers_front.sv]
module ers_front #(
  parameter int TIME_BITS = ers_pkg::TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic                 operation_i,
  input  logic [TIME_BITS-1:0] time_us_i,
  input  logic                 cmd_full_i,
  output logic                 cmd_push_o,
  output logic [TIME_BITS:0]   cmd_data_o
);
  import ers_pkg::*;

  logic                 measuring_q, measuring_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic                 xfer;

  assign full = cmd_full_i;
  assign xfer = push && !cmd_full_i;

  always_comb begin
    measuring_d = measuring_q;
    start_d     = start_q;
    cmd_push_o  = 1'b0;
    cmd_data_o  = {CMD_SAMPLE, {TIME_BITS{1'b0}}};
    if (xfer) begin
      if (operation_i == OP_SAMPLE) begin
        cmd_push_o = 1'b1;
      end else if (measuring_q) begin
        // closing edge: hand the pulse width to the back end
        cmd_push_o  = 1'b1;
        cmd_data_o  = {CMD_RANGE, time_us_i - start_q};
        measuring_d = 1'b0;
      end else begin
        start_d     = time_us_i;
        measuring_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      measuring_q <= 1'b0;
      start_q     <= '0;
    end else begin
      measuring_q <= measuring_d;
      start_q     <= start_d;
    end
  end
endmodule

[design/ers_back.sv]
module ers_back #(
  parameter int TIME_BITS  = ers_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = ers_pkg::COUNT_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cmd_empty_i,
  input  logic [TIME_BITS:0]                      cmd_data_i,
  output logic                                    cmd_pop_o,
  input  logic [ers_pkg::UPC_W-1:0]               us_per_cm_i,
  input  logic [ers_pkg::CFG_W-1:0]               sample_count_i,
  input  logic                                    res_full_i,
  output logic                                    res_push_o,
  output logic [ers_pkg::RES_FIXED_W+COUNT_BITS-1:0] res_data_o
);
  `include "assert_macros.svh"
  import ers_pkg::*;

  localparam int SW   = DIST_W + COUNT_BITS;
  localparam int SQW  = 2 * DIST_W + COUNT_BITS;
  localparam int PW   = 2 * SW;
  localparam int DW   = (TIME_BITS > PW) ? TIME_BITS : PW;
  localparam int RW   = DW + (DW % 2);
  localparam int HW   = RW / 2;
  localparam int RMW  = HW + 2;
  localparam int DVW  = (COUNT_BITS > UPC_W) ? COUNT_BITS : UPC_W;
  localparam int CNTW = $clog2(DW + 1);
  localparam int CW   = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  state_e                  state_q, state_d;
  div_tag_e                tag_q, tag_d;
  logic [CNTW-1:0]         cnt_q, cnt_d;
  logic [DW-1:0]           dq_q, dq_d;
  logic [DVW-1:0]          rem_q, rem_d, dvs_q, dvs_d;
  logic [2*DIST_W-1:0]     sq_q, sq_d;
  logic [RW-1:0]           sv_q, sv_d;
  logic [HW-1:0]           root_q, root_d;
  logic [RMW-1:0]          srem_q, srem_d;
  logic [DIST_W-1:0]       cur_q, cur_d, mean_q, mean_d, std_q, std_d;
  logic [SW-1:0]           sum_q, sum_d;
  logic [SQW-1:0]          sqs_q, sqs_d;
  logic [COUNT_BITS-1:0]   bcnt_q, bcnt_d, idx_q, idx_d;
  logic                    done_q, done_d;

  logic [CW-1:0]           sc_ext;
  logic [COUNT_BITS-1:0]   n_eff, bnext;
  logic [DVW:0]            rem_sh, rsub;
  logic                    ge;
  logic [RMW:0]            s_sh, trial, ssub;
  logic                    sge;
  logic [DW-1:0]           sqs_ext, num;
  logic [PW-1:0]           prod;
  logic [DIST_W-1:0]       dq_sat, root_sat;
  logic [HW+DIST_W-1:0]    root_ext;

  always_comb begin
    sc_ext = CW'(sample_count_i);
    if (sc_ext < CW'(2)) begin
      n_eff = COUNT_BITS'(2);
    end else if (sc_ext > CW'({COUNT_BITS{1'b1}})) begin
      n_eff = {COUNT_BITS{1'b1}};
    end else begin
      n_eff = sc_ext[COUNT_BITS-1:0];
    end
  end

  assign bnext    = bcnt_q + 1'b1;
  assign rem_sh   = {rem_q, dq_q[DW-1]};
  assign rsub     = rem_sh - {1'b0, dvs_q};
  assign ge       = (rem_sh >= {1'b0, dvs_q});
  assign s_sh     = {srem_q[RMW-2:0], sv_q[RW-1:RW-2]};
  assign trial    = (RMW+1)'({root_q, 2'b01});
  assign ssub     = s_sh - trial;
  assign sge      = (s_sh >= trial);
  assign sqs_ext  = DW'(sqs_q);
  assign num      = (sqs_ext >= dq_q) ? sqs_ext - dq_q : '0;
  assign prod     = PW'(sum_q) * PW'(sum_q);
  assign dq_sat   = (|dq_q[DW-1:DIST_W]) ? DIST_MAX : dq_q[DIST_W-1:0];
  assign root_ext = (HW+DIST_W)'(root_q);
  assign root_sat = (|root_ext[HW+DIST_W-1:DIST_W]) ? DIST_MAX : root_ext[DIST_W-1:0];

  always_comb begin
    state_d = state_q;
    tag_d   = tag_q;
    cnt_d   = cnt_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    sq_d    = sq_q;
    sv_d    = sv_q;
    root_d  = root_q;
    srem_d  = srem_q;
    cur_d   = cur_q;
    mean_d  = mean_q;
    std_d   = std_q;
    sum_d   = sum_q;
    sqs_d   = sqs_q;
    bcnt_d  = bcnt_q;
    idx_d   = idx_q;
    done_d  = done_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_data_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_e'(cmd_data_i[TIME_BITS]) == CMD_SAMPLE) begin
            sq_d    = (2*DIST_W)'(cur_q) * (2*DIST_W)'(cur_q);
            state_d = ST_ACCUM;
          end else if (us_per_cm_i == '0) begin
            cur_d = DIST_MAX;
          end else begin
            dq_d    = DW'(cmd_data_i[TIME_BITS-1:0]);
            rem_d   = '0;
            dvs_d   = DVW'(us_per_cm_i);
            cnt_d   = CNTW'(DW);
            tag_d   = DIV_RANGE;
            state_d = ST_DIV;
          end
        end
      end
      ST_ACCUM: begin
        sum_d   = sum_q + SW'(cur_q);
        sqs_d   = sqs_q + SQW'(sq_q);
        idx_d   = bcnt_q;
        bcnt_d  = bnext;
        done_d  = (bnext >= n_eff);
        state_d = ST_EMIT_D;
      end
      ST_EMIT_D: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_data_o = {KIND_DIST, cur_q, idx_q, {DIST_W{1'b0}}, {DIST_W{1'b0}}, !done_q};
          if (done_q) begin
            dq_d    = DW'(sum_q);
            rem_d   = '0;
            dvs_d   = DVW'(n_eff);
            cnt_d   = CNTW'(DW);
            tag_d   = DIV_MEAN;
            state_d = ST_DIV;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          rem_d = '0;
          cnt_d = CNTW'(DW);
          case (tag_q)
            DIV_RANGE: begin
              cur_d   = dq_sat;
              state_d = ST_IDLE;
            end
            DIV_MEAN: begin
              mean_d = dq_sat;
              dq_d   = DW'(prod);
              dvs_d  = DVW'(n_eff);
              tag_d  = DIV_SSN;
            end
            DIV_SSN: begin
              dq_d  = num;
              dvs_d = DVW'(n_eff - 1'b1);
              tag_d = DIV_VAR;
            end
            DIV_VAR: begin
              sv_d    = RW'(dq_q);
              root_d  = '0;
              srem_d  = '0;
              cnt_d   = CNTW'(HW);
              state_d = ST_SQRT;
            end
            default: state_d = ST_IDLE;
          endcase
        end else begin
          dq_d  = {dq_q[DW-2:0], ge};
          rem_d = ge ? rsub[DVW-1:0] : rem_sh[DVW-1:0];
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_SQRT: begin
        if (cnt_q == '0) begin
          std_d   = root_sat;
          state_d = ST_EMIT_S;
        end else begin
          sv_d = sv_q << 2;
          if (sge) begin
            srem_d = ssub[RMW-1:0];
            root_d = {root_q[HW-2:0], 1'b1};
          end else begin
            srem_d = s_sh[RMW-1:0];
            root_d = {root_q[HW-2:0], 1'b0};
          end
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_EMIT_S: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_data_o = {KIND_STAT, {DIST_W{1'b0}}, {COUNT_BITS{1'b0}}, mean_q, std_q, 1'b1};
          sum_d   = '0;
          sqs_d   = '0;
          bcnt_d  = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tag_q   <= DIV_RANGE;
      cnt_q   <= '0;
      cur_q   <= '0;
      sum_q   <= '0;
      sqs_q   <= '0;
      bcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tag_q   <= tag_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      sum_q   <= sum_d;
      sqs_q   <= sqs_d;
      bcnt_q  <= bcnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    sq_q   <= sq_d;
    sv_q   <= sv_d;
    root_q <= root_d;
    srem_q <= srem_d;
    mean_q <= mean_d;
    std_q  <= std_d;
    idx_q  <= idx_d;
  end

  `ERS_ASSERT_IMP(a_div_nonzero, state_q == ST_DIV, dvs_q != '0)
  `ERS_ASSERT_IMP(a_pop_idle, cmd_pop_o, state_q == ST_IDLE)
  `ERS_ASSERT_NEXT(a_sqrt_done, state_q == ST_SQRT && cnt_q == '0, state_q == ST_EMIT_S)
  `ERS_ASSERT_NEXT(a_batch_clear, state_q == ST_EMIT_S && !res_full_i,
                   sum_q == '0 && sqs_q == '0 && bcnt_q == '0)
endmodule

[design/echo_ranger_with_statistics_unit.sv]
// channel  | direction | handshake   | payload
// input    | in        | push / full | operation_i, time_us_i
// result   | out       | empty / pop | kind_o, distance_cm_o, sample_index_o,
//          |           |             | mean_cm_o, std_dev_cm_o, last_o
// config   | in        | cfg_we_i    | cfg_index_i, cfg_data_i
//
// Edge events are handled in the front; an opening edge ends there.
// A closing edge uses the shared restoring divider, a quotient bit per cycle over
// DW = max(TIME_BITS, 32+2*COUNT_BITS) bits; a zero us_per_cm saturates instead.
// A sample is squared, accumulated and emitted; a batch close adds divider passes
// for mean, sum^2/n and variance, a square root and the statistics transfer.
// Reset is asynchronous, active low; no clearing pass.
// A two-entry queue on each side lets front and back stall independently.
module echo_ranger_with_statistics_unit #(
  parameter int TIME_BITS  = ers_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = ers_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        operation_i,
  input  logic [TIME_BITS-1:0]        time_us_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        kind_o,
  output logic [ers_pkg::DIST_W-1:0]  distance_cm_o,
  output logic [COUNT_BITS-1:0]       sample_index_o,
  output logic [ers_pkg::DIST_W-1:0]  mean_cm_o,
  output logic [ers_pkg::DIST_W-1:0]  std_dev_cm_o,
  output logic                        last_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [ers_pkg::CFG_W-1:0]   cfg_data_i
);
  import ers_pkg::*;

  localparam int RES_W = RES_FIXED_W + COUNT_BITS;

  logic [UPC_W-1:0]   upc_q;
  logic [CFG_W-1:0]   scnt_q;
  logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [TIME_BITS:0] cmd_wdata, cmd_rdata;
  logic               res_push, res_full;
  logic [RES_W-1:0]   res_wdata, res_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= US_PER_CM_RST;
      scnt_q <= SAMPLE_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_US_PER_CM:    upc_q  <= cfg_data_i[UPC_W-1:0];
        REG_SAMPLE_COUNT: scnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ers_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk_i, .rst_ni, .push, .full, .operation_i, .time_us_i,
    .cmd_full_i(cmd_full), .cmd_push_o(cmd_push), .cmd_data_o(cmd_wdata)
  );

  ers_fifo #(.WIDTH(TIME_BITS + 1), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
    .clk_i, .rst_ni, .push_i(cmd_push), .data_i(cmd_wdata), .full_o(cmd_full),
    .pop_i(cmd_pop), .data_o(cmd_rdata), .empty_o(cmd_empty)
  );

  ers_back #(.TIME_BITS(TIME_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i, .rst_ni, .cmd_empty_i(cmd_empty), .cmd_data_i(cmd_rdata),
    .cmd_pop_o(cmd_pop), .us_per_cm_i(upc_q), .sample_count_i(scnt_q),
    .res_full_i(res_full), .res_push_o(res_push), .res_data_o(res_wdata)
  );

  ers_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk_i, .rst_ni, .push_i(res_push), .data_i(res_wdata), .full_o(res_full),
    .pop_i(pop), .data_o(res_rdata), .empty_o(empty)
  );

  assign kind_o         = res_rdata[RES_W-1];
  assign distance_cm_o  = res_rdata[RES_W-2 -: DIST_W];
  assign sample_index_o = res_rdata[RES_W-2-DIST_W -: COUNT_BITS];
  assign mean_cm_o      = res_rdata[2*DIST_W -: DIST_W];
  assign std_dev_cm_o   = res_rdata[DIST_W -: DIST_W];
  assign last_o         = res_rdata[0];
endmodule

[test/echo_ranger_with_statistics_unit_tb.sv]
module echo_ranger_with_statistics_unit_tb;
  import ers_pkg::*;

  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 62;
  localparam int NUM_PHASES    = 15;

  typedef struct packed {
    logic        kind;
    logic [15:0] distance;
    logic [11:0] index;
    logic [15:0] mean;
    logic [15:0] std_dev;
    logic        last;
  } range_res_t;

  typedef struct {
    bit          is_reg;
    logic        op;
    logic [31:0] stamp;
    bit          has_dist;
    logic [15:0] exp_dist;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        operation_i = OP_EDGE;
  logic [31:0] time_us_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind_o, last_o;
  logic [15:0] distance_cm_o, mean_cm_o, std_dev_cm_o;
  logic [11:0] sample_index_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = REG_US_PER_CM;
  logic [11:0] cfg_data_i = '0;

  echo_ranger_with_statistics_unit u_top (
    .clk_i, .rst_ni, .push, .full, .operation_i, .time_us_i, .empty, .pop,
    .kind_o, .distance_cm_o, .sample_index_o, .mean_cm_o, .std_dev_cm_o,
    .last_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // shadow state
  logic [7:0]           upc_reg = US_PER_CM_RST;
  logic [11:0]          batch_reg = SAMPLE_COUNT_RST;
  bit                   in_pulse;
  logic [31:0]          pulse_start;
  logic [15:0]          cur_dist;
  logic [11:0]          batch_pos;
  longint unsigned      dist_sum, sq_sum;
  logic [15:0]          last_pred_dist;

  range_res_t           pending_res[$];
  int                   errors, n_edges, n_samples, n_stats, n_reg_writes;
  int                   burst_left, idle_cycles;
  int                   hold_reqs, hold_seen, hold_cnt, pat_mode, pat_cnt, rx_cnt;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, trial;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (64'd1 << b);
      if (trial * trial <= v) res = trial;
    end
    return res;
  endfunction

  function automatic logic [15:0] clip16(longint unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic range_predict(logic op, logic [31:0] stamp);
    longint unsigned n, mean, spread, var_q;
    logic [31:0] elapsed;
    range_res_t r;
    if (op == OP_EDGE) begin
      n_edges++;
      if (in_pulse) begin
        elapsed = stamp - pulse_start;
        cur_dist = (upc_reg == 0) ? DIST_MAX : clip16(elapsed / upc_reg);
        in_pulse = 0;
      end else begin
        pulse_start = stamp;
        in_pulse = 1;
      end
    end else begin
      n_samples++;
      n = (batch_reg < 2) ? 2 : batch_reg;
      r = '0;
      r.kind = KIND_DIST;
      r.distance = cur_dist;
      r.index = batch_pos;
      last_pred_dist = cur_dist;
      dist_sum += cur_dist;
      sq_sum += longint'(cur_dist) * cur_dist;
      batch_pos = batch_pos + 1'b1;
      r.last = (batch_pos < n);
      pending_res.push_back(r);
      if (batch_pos >= n) begin
        n_stats++;
        mean = dist_sum / n;
        spread = (dist_sum * dist_sum) / n;
        var_q = (sq_sum >= spread) ? (sq_sum - spread) / (n - 1) : 0;
        r = '0;
        r.kind = KIND_STAT;
        r.mean = clip16(mean);
        r.std_dev = clip16(floor_sqrt(var_q));
        r.last = 1'b1;
        pending_res.push_back(r);
        batch_pos = '0;
        dist_sum = 0;
        sq_sum = 0;
      end
    end
  endtask

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want, rx_cnt);
    errors++;
  endtask

  // transfers on both sides, prediction and checking
  always @(posedge clk_i) begin
    range_res_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (push && !full) begin
        range_predict(operation_i, time_us_i);
        idle_cycles = 0;
      end
      if (pop && !empty) begin
        idle_cycles = 0;
        rx_cnt++;
        if (pending_res.size() == 0) begin
          report("unexpected result, kind", kind_o, 0);
        end else begin
          want = pending_res.pop_front();
          if (kind_o !== want.kind) report("kind", kind_o, want.kind);
          if (distance_cm_o !== want.distance) report("distance", distance_cm_o, want.distance);
          if (sample_index_o !== want.index) report("sample_index", sample_index_o, want.index);
          if (mean_cm_o !== want.mean) report("mean", mean_cm_o, want.mean);
          if (std_dev_cm_o !== want.std_dev) report("std_dev", std_dev_cm_o, want.std_dev);
          if (last_o !== want.last) report("last", last_o, want.last);
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result side stall pattern
  always @(negedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_cnt = HOLD_CYCLES;
    end
    if (pat_cnt == 0) begin
      pat_mode = $urandom_range(0, 2);
      pat_cnt = $urandom_range(5, 60);
    end
    pat_cnt--;
    if (hold_cnt > 0) begin
      hold_cnt--;
      pop <= 1'b0;
    end else begin
      case (pat_mode)
        0: pop <= 1'b1;
        1: pop <= $urandom_range(0, 1);
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send(logic op, logic [31:0] stamp);
    @(negedge clk_i);
    push <= 1'b1;
    operation_i <= op;
    time_us_i <= stamp;
    do @(posedge clk_i); while (full);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      @(negedge clk_i);
      push <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [11:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == REG_US_PER_CM) upc_reg = data[7:0];
    else batch_reg = data;
    n_reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int items);
    int k, kind_sel;
    logic [31:0] base, span;
    k = 0;
    while (k < items) begin
      kind_sel = $urandom_range(0, 9);
      if (kind_sel < 6) begin
        base = $urandom;
        case ($urandom_range(0, 3))
          0: span = $urandom;
          1: span = upc_reg * $urandom_range(0, 65535) + $urandom_range(0, upc_reg);
          default: span = $urandom_range(0, upc_reg * 300 + 5);
        endcase
        if (in_pulse) send(OP_EDGE, $urandom);
        send(OP_EDGE, base);
        send(OP_EDGE, base + span);
        k += 2;
        repeat ($urandom_range(1, 3)) begin
          send(OP_SAMPLE, $urandom);
          k++;
        end
      end else if (kind_sel < 8) begin
        send(OP_SAMPLE, $urandom);
        k++;
      end else begin
        send(OP_EDGE, $urandom);
        k++;
      end
    end
  endtask

  dir_row_t dir_rows[$] = '{
    '{0, OP_SAMPLE, 32'd0,          1, 16'd0},
    '{0, OP_EDGE,   32'd100,        0, 16'd0},
    '{0, OP_EDGE,   32'd680,        0, 16'd0},
    '{0, OP_SAMPLE, 32'hFFFFFFFF,   1, 16'd10},
    '{0, OP_EDGE,   32'hFFFFFFF0,   0, 16'd0},
    '{0, OP_EDGE,   32'd290,        0, 16'd0},
    '{0, OP_SAMPLE, 32'd0,          1, 16'd5},
    '{0, OP_EDGE,   32'd0,          0, 16'd0},
    '{0, OP_EDGE,   32'hFFFFFFFF,   0, 16'd0},
    '{0, OP_SAMPLE, 32'd0,          1, 16'hFFFF},
    '{0, OP_EDGE,   32'h55555555,   0, 16'd0},
    '{0, OP_EDGE,   32'h55555555,   0, 16'd0},
    '{0, OP_SAMPLE, 32'hAAAAAAAA,   1, 16'd0},
    '{1, REG_US_PER_CM, 32'd0,      0, 16'd0},
    '{0, OP_EDGE,   32'd7,          0, 16'd0},
    '{0, OP_EDGE,   32'd8,          0, 16'd0},
    '{0, OP_SAMPLE, 32'd0,          1, 16'hFFFF},
    '{1, REG_US_PER_CM, 32'd255,    0, 16'd0},
    '{1, REG_SAMPLE_COUNT, 32'd0,   0, 16'd0},
    '{0, OP_EDGE,   32'd1000,       0, 16'd0},
    '{0, OP_EDGE,   32'd1765,       0, 16'd0},
    '{0, OP_SAMPLE, 32'd0,          1, 16'd3},
    '{1, REG_SAMPLE_COUNT, 32'd1,   0, 16'd0},
    '{0, OP_SAMPLE, 32'd0,          1, 16'd3},
    '{0, OP_SAMPLE, 32'd0,          1, 16'd3}
  };

  initial begin
    logic [7:0]  upc_pick;
    logic [11:0] cnt_pick;
    cur_dist = '0;
    pulse_start = '0;
    batch_pos = '0;
    burst_left = 5;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        drain();
        write_reg(dir_rows[i].op, dir_rows[i].stamp[11:0]);
      end else begin
        send(dir_rows[i].op, dir_rows[i].stamp);
        if (dir_rows[i].has_dist) begin
          @(negedge clk_i);
          push <= 1'b0;
          if (last_pred_dist !== dir_rows[i].exp_dist)
            report("directed distance", last_pred_dist, dir_rows[i].exp_dist);
        end
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p % 5)
        0: upc_pick = 8'd1;
        1: upc_pick = 8'd255;
        2: upc_pick = 8'd58;
        3: upc_pick = (p == 3) ? 8'd0 : 8'($urandom_range(1, 255));
        default: upc_pick = $urandom;
      endcase
      case (p)
        4: cnt_pick = 12'd4095;
        7: cnt_pick = 12'd1;
        9: cnt_pick = 12'd2;
        default: cnt_pick = $urandom_range(2, 16);
      endcase
      write_reg(REG_US_PER_CM, upc_pick);
      write_reg(REG_SAMPLE_COUNT, cnt_pick);
      if (p == 6) hold_reqs++;
      random_phase(PHASE_ITEMS);
    end

    drain();
    $display("covered %0d edges, %0d samples, %0d batch closes, %0d register writes",
             n_edges, n_samples, n_stats, n_reg_writes);
    $display("divisors 0..255, batch sizes 0..4095, timer wrap, long result stall");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
